// ===== sv/xxh64_stream_hash_top_macros.svh =====
// Assertion macros for the xxh64 stream hash checker.
`ifndef XXH64_STREAM_HASH_TOP_MACROS_SVH
`define XXH64_STREAM_HASH_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define XXH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define XXH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/xxh_pkg.sv =====
// Shared constants, types and helpers for the xxh64 stream hash.
package xxh_pkg;

	localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] P3 = 64'h165667B19E3779F9;
	localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

	localparam logic [3:0] FULL_WORD = 4'd8;
	localparam logic [3:0] HALF_WORD = 4'd4;

	typedef struct packed {
		logic [63:0] w;
		logic [3:0]  vb;
		logic        last;
	} item_t;

	typedef struct packed {
		logic        go;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] prod;
	} mul_rsp_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

endpackage

// ===== sv/xxh_front.sv =====
// Front end: accepts words, settles the byte count and queues items for the back end.
module xxh_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [63:0]   data_word,
	input  logic [3:0]    valid_bytes,
	input  logic          last,
	output logic          item_valid,
	output xxh_pkg::item_t item,
	input  logic          item_pop
);
	import xxh_pkg::*;

	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr;
	logic       rd;
	logic [3:0] vb_eff;

	// a word that is not last, or claims more than eight bytes, counts as full
	assign vb_eff = (!last || valid_bytes > FULL_WORD) ? FULL_WORD : valid_bytes;

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = mem_q[rp_q];
	assign wr         = push && !full;
	assign rd         = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= '{w: data_word, vb: vb_eff, last: last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

// ===== sv/xxh_mul.sv =====
// Shared 64x64 low-half multiplier built from one 32x32 multiplier.
module xxh_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  xxh_pkg::mul_req_t req,
	output xxh_pkg::mul_rsp_t rsp
);
	import xxh_pkg::*;

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] p_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] x;
	logic [31:0] y;
	logic [63:0] m;

	always_comb begin
		case (cnt_q)
			2'd0: begin
				x = a_q[31:0];
				y = b_q[31:0];
			end
			2'd1: begin
				x = a_q[31:0];
				y = b_q[63:32];
			end
			default: begin
				x = a_q[63:32];
				y = b_q[31:0];
			end
		endcase
	end

	assign m = {32'd0, x} * {32'd0, y};

	assign rsp.done = done_q;
	assign rsp.prod = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
			a_q    <= '0;
			b_q    <= '0;
			p_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				a_q    <= req.a;
				b_q    <= req.b;
				cnt_q  <= 2'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				case (cnt_q)
					2'd0: p_q <= m;
					2'd1: p_q[63:32] <= p_q[63:32] + m[31:0];
					default: begin
						p_q[63:32] <= p_q[63:32] + m[31:0];
						busy_q     <= 1'b0;
						done_q     <= 1'b1;
					end
				endcase
			end
		end
	end

endmodule

// ===== sv/xxh_back.sv =====
// Back end: stripe buffer, lane rounds, finalization and the result register.
module xxh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       seed,
	input  logic              item_valid,
	input  xxh_pkg::item_t    item,
	output logic              item_pop,
	output xxh_pkg::mul_req_t mreq,
	input  xxh_pkg::mul_rsp_t mrsp,
	output logic              empty,
	input  logic              pop,
	output logic [63:0]       hash_value
);
	import xxh_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_ABS_A = 16'h0002,
		S_ABS_B = 16'h0004,
		S_CONV  = 16'h0008,
		S_RND_A = 16'h0010,
		S_RND_B = 16'h0020,
		S_RND_C = 16'h0040,
		S_TAILW = 16'h0080,
		S_T4_A  = 16'h0100,
		S_T4_B  = 16'h0200,
		S_BYTES = 16'h0400,
		S_T1_A  = 16'h0800,
		S_T1_B  = 16'h1000,
		S_MIX_A = 16'h2000,
		S_MIX_B = 16'h4000,
		S_OUT   = 16'h8000
	} state_t;

	state_t      state_q;
	logic [63:0] lane_q [4];
	logic [63:0] buf_q [4];
	logic [1:0]  fill_q;
	logic [63:0] total_q;
	logic        seen_q;
	logic [63:0] w_q;
	logic [3:0]  vb_q;
	logic        last_q;
	logic [63:0] h_q;
	logic [63:0] r_q;
	logic [1:0]  idx_q;
	logic        merge_q;
	logic [3:0]  pos_q;
	logic        wait_q;
	logic        out_valid_q;
	logic [63:0] hash_q;
	logic        mul_st;
	logic [63:0] rnd_x;
	logic        done;

	assign item_pop   = (state_q == S_IDLE) && item_valid;
	assign empty      = !out_valid_q;
	assign hash_value = hash_q;
	assign done       = mrsp.done;
	assign rnd_x      = h_q ^ mrsp.prod;

	always_comb begin
		mul_st = 1'b1;
		mreq.a = '0;
		mreq.b = '0;
		case (state_q)
			S_ABS_A: begin
				mreq.a = buf_q[idx_q];
				mreq.b = P2;
			end
			S_RND_A: begin
				mreq.a = merge_q ? lane_q[idx_q] : buf_q[idx_q];
				mreq.b = P2;
			end
			S_ABS_B, S_RND_B, S_RND_C, S_T1_B: begin
				mreq.a = r_q;
				mreq.b = P1;
			end
			S_T4_A: begin
				mreq.a = {32'd0, w_q[31:0]};
				mreq.b = P1;
			end
			S_T4_B: begin
				mreq.a = r_q;
				mreq.b = P2;
			end
			S_T1_A: begin
				mreq.a = {56'd0, w_q[{pos_q[2:0], 3'b000} +: 8]};
				mreq.b = P5;
			end
			S_MIX_A: begin
				mreq.a = h_q ^ (h_q >> 33);
				mreq.b = P2;
			end
			S_MIX_B: begin
				mreq.a = r_q;
				mreq.b = P3;
			end
			default: mul_st = 1'b0;
		endcase
		mreq.go = mul_st && !wait_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= 2'd0;
			total_q     <= '0;
			seen_q      <= 1'b0;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
			w_q         <= '0;
			vb_q        <= '0;
			last_q      <= 1'b0;
			h_q         <= '0;
			r_q         <= '0;
			idx_q       <= '0;
			merge_q     <= 1'b0;
			pos_q       <= '0;
			hash_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				lane_q[i] <= '0;
				buf_q[i]  <= '0;
			end
		end else begin
			if (mreq.go) wait_q <= 1'b1;
			else if (done) wait_q <= 1'b0;
			if (pop && out_valid_q) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						w_q     <= item.w;
						vb_q    <= item.vb;
						last_q  <= item.last;
						total_q <= total_q + {60'd0, item.vb};
						if (item.vb == FULL_WORD) begin
							buf_q[fill_q] <= item.w;
							if (fill_q == 2'd3) begin
								idx_q <= 2'd0;
								if (!seen_q) begin
									lane_q[0] <= seed + P1 + P2;
									lane_q[1] <= seed + P2;
									lane_q[2] <= seed;
									lane_q[3] <= seed - P1;
								end
								state_q <= S_ABS_A;
							end else begin
								fill_q <= fill_q + 2'd1;
								if (item.last) state_q <= S_CONV;
							end
						end else if (item.last) begin
							state_q <= S_CONV;
						end
					end
				end
				S_ABS_A: if (done) begin
					r_q     <= rotl(lane_q[idx_q] + mrsp.prod, 31);
					state_q <= S_ABS_B;
				end
				S_ABS_B: if (done) begin
					lane_q[idx_q] <= mrsp.prod;
					if (idx_q == 2'd3) begin
						seen_q  <= 1'b1;
						fill_q  <= 2'd0;
						idx_q   <= 2'd0;
						state_q <= last_q ? S_CONV : S_IDLE;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_ABS_A;
					end
				end
				S_CONV: begin
					idx_q <= 2'd0;
					if (seen_q) begin
						h_q <= rotl(lane_q[0], 1) + rotl(lane_q[1], 7) +
							rotl(lane_q[2], 12) + rotl(lane_q[3], 18);
						merge_q <= 1'b1;
						state_q <= S_RND_A;
					end else begin
						h_q     <= seed + P5 + total_q;
						merge_q <= 1'b0;
						state_q <= S_TAILW;
					end
				end
				S_RND_A: if (done) begin
					r_q     <= rotl(mrsp.prod, 31);
					state_q <= S_RND_B;
				end
				S_RND_B: if (done) begin
					r_q     <= merge_q ? rnd_x : rotl(rnd_x, 27);
					state_q <= S_RND_C;
				end
				S_RND_C: if (done) begin
					if (merge_q) begin
						if (idx_q == 2'd3) begin
							// fold in the length once all lanes are merged
							h_q     <= mrsp.prod + P4 + total_q;
							merge_q <= 1'b0;
							idx_q   <= 2'd0;
							state_q <= S_TAILW;
						end else begin
							h_q     <= mrsp.prod + P4;
							idx_q   <= idx_q + 2'd1;
							state_q <= S_RND_A;
						end
					end else begin
						h_q     <= mrsp.prod + P4;
						idx_q   <= idx_q + 2'd1;
						state_q <= S_TAILW;
					end
				end
				S_TAILW: begin
					if (idx_q < fill_q) state_q <= S_RND_A;
					else if (vb_q == FULL_WORD) state_q <= S_MIX_A;
					else if (vb_q >= HALF_WORD) state_q <= S_T4_A;
					else begin
						pos_q   <= 4'd0;
						state_q <= S_BYTES;
					end
				end
				S_T4_A: if (done) begin
					r_q     <= rotl(rnd_x, 23);
					state_q <= S_T4_B;
				end
				S_T4_B: if (done) begin
					h_q     <= mrsp.prod + P3;
					pos_q   <= HALF_WORD;
					state_q <= S_BYTES;
				end
				S_BYTES: state_q <= (pos_q < vb_q) ? S_T1_A : S_MIX_A;
				S_T1_A: if (done) begin
					r_q     <= rotl(rnd_x, 11);
					state_q <= S_T1_B;
				end
				S_T1_B: if (done) begin
					h_q     <= mrsp.prod;
					pos_q   <= pos_q + 4'd1;
					state_q <= S_BYTES;
				end
				S_MIX_A: if (done) begin
					r_q     <= mrsp.prod ^ (mrsp.prod >> 29);
					state_q <= S_MIX_B;
				end
				S_MIX_B: if (done) begin
					h_q     <= mrsp.prod ^ (mrsp.prod >> 32);
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the result register is free
					if (!out_valid_q) begin
						hash_q      <= h_q;
						out_valid_q <= 1'b1;
						fill_q      <= 2'd0;
						total_q     <= '0;
						seen_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/xxh64_stream_hash_top.sv =====
// Top level: XXH64 hash of a word stream; a 2-item queue takes one word per cycle while not full.
// A non-last word that does not complete a stripe is only stored in the stripe buffer.
// A word that completes a 32-byte stripe runs a round of 8 products on the shared multiplier.
// The last word adds a stripe round when it completes a stripe, a lane merge if a stripe was seen,
// a round per buffered tail word, and with fewer than eight bytes a 4-byte step for four or more
// bytes and a step per further byte; each 64-bit product comes from one 32x32 multiplier.
// arst_n clears the queue, the message state, the result register and sets the seed to zero.
module xxh64_stream_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] hash_value,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);
	import xxh_pkg::*;

	logic        item_valid;
	item_t       item;
	logic        item_pop;
	mul_req_t    mreq;
	mul_rsp_t    mrsp;
	logic [63:0] seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= '0;
		else if (cfg_we) seed_q <= cfg_wdata;
	end

	xxh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last        (last),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop)
	);

	xxh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	xxh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.mreq       (mreq),
		.mrsp       (mrsp),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);

endmodule

// ===== sv/xxh_chk.sv =====
// Port-level checker for the xxh64 stream hash, bound to the top level.
module xxh_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [63:0] hash_value
);
`include "xxh64_stream_hash_top_macros.svh"

	// a waiting result stays put until taken
	`XXH_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(hash_value), "result changed while waiting")
	// results are spaced: a taken result leaves the output empty for a cycle
	`XXH_ASSERT_NEXT(a_drain, !empty && pop, empty, "new result right after pop")
	// the input queue only fills on accepted items
	`XXH_ASSERT_NEXT(a_nofill, !full && !push, !full, "queue filled without an item")
	// a waiting result carries a known value
	`XXH_ASSERT_NOW(a_known, !empty, !$isunknown(hash_value), "unknown bits on a waiting result")

endmodule

bind xxh64_stream_hash_top xxh_chk u_chk (.*);
